/* rtl/eaw_pkg.sv */
// eaw_pkg: shared widths, codes and the range entry type of the
// east asian width range lookup block. no dependencies.
package eaw_pkg;

  localparam int CP_W              = 21;
  localparam int CLASS_W           = 3;
  localparam int SLOT_W            = 10;
  localparam int COUNT_W           = 11;
  localparam int TABLE_ENTRIES_DEF = 1024;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [CLASS_W-1:0] CLASS_H = 3'd1;

  typedef struct packed {
    logic [CP_W-1:0]    first;
    logic [CP_W-1:0]    last;
    logic [CLASS_W-1:0] cls;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // inclusive range test, an inverted range holds nothing
  function automatic logic holds(entry_t e, logic [CP_W-1:0] cp);
    holds = (cp >= e.first) && (cp <= e.last);
  endfunction

endpackage

/* rtl/eaw_ram.sv */
// eaw_ram: generic single write, single read ram with registered read data.
// no package dependencies.
module eaw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/east_asian_width_range_lookup.sv */
// east_asian_width_range_lookup: top level, range table and binary search sequencer.
// uses eaw_pkg and eaw_ram.
// operation: a load item gives no result. a query item gives its result when its
// search is done and the output register is free; an earlier result still held by
// out_stall keeps the query waiting in its last step for as long as it is held. the
// next item is taken in the cycle after the result is handed over. the single ram
// read port gives one probe of the search per cycle.
// reset: rst (synchronous) clears the sequencer, output valid and entry_count; the
// table itself is not cleared and must be loaded before it is searched.
module east_asian_width_range_lookup #(
  parameter int TABLE_ENTRIES = eaw_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration
  input  logic                        entry_count_we,
  input  logic [eaw_pkg::COUNT_W-1:0] entry_count,
  // input items
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        opcode,
  input  logic [eaw_pkg::SLOT_W-1:0]  entry_index,
  input  logic [eaw_pkg::CP_W-1:0]    range_first,
  input  logic [eaw_pkg::CP_W-1:0]    range_last,
  input  logic [eaw_pkg::CLASS_W-1:0] entry_class,
  input  logic [eaw_pkg::CP_W-1:0]    code_point,
  // result items
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [eaw_pkg::CLASS_W-1:0] width_class,
  output logic                        in_table
);

  import eaw_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0; // waiting for an item
  localparam logic [2:0] S_CHK0  = 3'd1; // slot 0 read back, test lower bound
  localparam logic [2:0] S_CHKN  = 3'd2; // last slot read back, test upper bound
  localparam logic [2:0] S_PROBE = 3'd3; // midpoint read back, narrow the bounds
  localparam logic [2:0] S_FINAL = 3'd4; // narrowed slot read back, last test
  localparam logic [2:0] S_EMIT  = 3'd5; // hand the result to the output register

  logic [2:0]         state, state_next;
  logic [COUNT_W-1:0] count_reg;
  logic [CP_W-1:0]    cp, cp_next;
  logic [IDX_W-1:0]   nlast, nlast_next;     // index of the last slot in use
  logic [IDX_W-1:0]   lo, lo_next;           // search_low
  logic [IDX_W-1:0]   hi, hi_next;           // search_high
  logic [IDX_W-1:0]   mid, mid_next;
  logic [CLASS_W-1:0] res_cls, res_cls_next;
  logic               res_hit, res_hit_next;

  // ram ports
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  entry_t             wr_entry;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic [ENTRY_W-1:0] rd_data;
  entry_t             rd_entry;

  logic               in_accept;
  logic               out_free;
  logic [CNT_W-1:0]   n_used;
  logic               probe_hit;
  logic               probe_up;
  logic [IDX_W-1:0]   lo_cand, hi_cand;
  logic [IDX_W:0]     mid_sum;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // loads go straight to the table, slots beyond the table are dropped
  assign wr_en          = in_accept && (opcode == OP_LOAD)
                          && (32'(entry_index) < TABLE_ENTRIES);
  assign wr_addr        = IDX_W'(entry_index);
  assign wr_entry.first = range_first;
  assign wr_entry.last  = range_last;
  assign wr_entry.cls   = entry_class;

  eaw_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_entry),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign rd_entry = entry_t'(rd_data);

  // a count above the table size means the whole table
  assign n_used = (32'(count_reg) > TABLE_ENTRIES) ? CNT_W'(TABLE_ENTRIES)
                                                   : CNT_W'(count_reg);

  // shared compare unit: one slot tested per cycle
  assign probe_hit = holds(rd_entry, cp);
  assign probe_up  = (rd_entry.last < cp);

  // candidate bounds: narrowed after a probe, or the full span after the bound checks
  always_comb begin
    if (state == S_PROBE) begin
      lo_cand = probe_up ? IDX_W'(mid + 1'b1) : lo;
      hi_cand = probe_up ? hi : mid;
    end else begin
      lo_cand = '0;
      hi_cand = nlast;
    end
  end

  assign mid_sum = {1'b0, lo_cand} + {1'b0, hi_cand};

  always_comb begin
    state_next   = state;
    cp_next      = cp;
    nlast_next   = nlast;
    lo_next      = lo;
    hi_next      = hi;
    mid_next     = mid;
    res_cls_next = res_cls;
    res_hit_next = res_hit;
    rd_en        = 1'b0;
    rd_addr      = '0;
    case (state)
      S_IDLE: begin
        if (in_accept && (opcode == OP_QUERY)) begin
          cp_next      = code_point;
          nlast_next   = IDX_W'(n_used - 1'b1);
          res_cls_next = CLASS_H;
          res_hit_next = 1'b0;
          if (n_used == '0) begin
            state_next = S_EMIT;
          end else begin
            rd_en      = 1'b1;
            rd_addr    = '0;
            state_next = S_CHK0;
          end
        end
      end
      S_CHK0: begin
        if (cp < rd_entry.first) begin
          state_next = S_EMIT;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = nlast;
          state_next = S_CHKN;
        end
      end
      S_CHKN, S_PROBE: begin
        if ((state == S_CHKN) && (cp > rd_entry.last)) begin
          // above the last range
          state_next = S_EMIT;
        end else if ((state == S_PROBE) && probe_hit) begin
          res_cls_next = rd_entry.cls;
          res_hit_next = 1'b1;
          state_next   = S_EMIT;
        end else begin
          lo_next = lo_cand;
          hi_next = hi_cand;
          rd_en   = 1'b1;
          if (lo_cand < hi_cand) begin
            mid_next   = mid_sum[IDX_W:1];
            rd_addr    = mid_sum[IDX_W:1];
            state_next = S_PROBE;
          end else begin
            rd_addr    = lo_cand;
            state_next = S_FINAL;
          end
        end
      end
      S_FINAL: begin
        if (probe_hit) begin
          res_cls_next = rd_entry.cls;
          res_hit_next = 1'b1;
        end
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count_reg <= '0;
      lo        <= '0;
      hi        <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      lo    <= lo_next;
      hi    <= hi_next;
      if (entry_count_we) begin
        count_reg <= entry_count;
      end
      // a new result replaces a taken one, otherwise a taken one empties the register
      if ((state == S_EMIT) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    cp      <= cp_next;
    nlast   <= nlast_next;
    mid     <= mid_next;
    res_cls <= res_cls_next;
    res_hit <= res_hit_next;
    if ((state == S_EMIT) && out_free) begin
      width_class <= res_cls;
      in_table    <= res_hit;
    end
  end

  // an unmatched code point always reports the halfwidth class
  a_miss_is_h: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !in_table) |-> (width_class == CLASS_H))
    else $error("miss reported with a class other than halfwidth");

  // a probe only happens on a span of at least two slots, midpoint inside it
  a_probe_span: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROBE) |-> ((lo < hi) && (lo <= mid) && (mid < hi)))
    else $error("probe outside the search span");

  // the final test sees a fully narrowed span
  a_final_narrow: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINAL) |-> (lo == hi))
    else $error("final test reached with an open span");

  // an empty table answers without touching the ram
  a_empty_table: assert property (@(posedge clk) disable iff (rst)
    (in_accept && (opcode == OP_QUERY) && (n_used == '0)) |=> (state == S_EMIT))
    else $error("empty table query did not go straight to the result");

endmodule
